>>> design/pu_pkg.sv
// Package for the permutation unrank block: request/result types, sizes,
// the factorial table and the control structs passed between submodules.
// No dependencies.
package pu_pkg;

  // Largest permutation length served
  localparam int unsigned MAX_N  = 12;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned RANK_W = 29;
  localparam int unsigned ELEM_W = 4;
  // Quotient digit width: a digit is always below MAX_N
  localparam int unsigned QW     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int unsigned IDX_W  = QW;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [QW-1:0]     quot_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    len_t  length;
    rank_t rank;
  } pu_req_t;

  typedef struct packed {
    elem_t element;
    logic  last;
    logic  error;
  } pu_result_t;

  // Divider response
  typedef struct packed {
    logic  done;
    quot_t quot;
    rank_t rem;
  } pu_div_rsp_t;

  // Pool command
  typedef struct packed {
    logic init;
    logic take;
    idx_t idx;
  } pu_pool_cmd_t;

  // m! for m in 0..MAX_N, zero outside
  function automatic rank_t fact_f(input len_t m);
    rank_t f;
    unique case (m)
      4'd0:    f = 29'd1;
      4'd1:    f = 29'd1;
      4'd2:    f = 29'd2;
      4'd3:    f = 29'd6;
      4'd4:    f = 29'd24;
      4'd5:    f = 29'd120;
      4'd6:    f = 29'd720;
      4'd7:    f = 29'd5040;
      4'd8:    f = 29'd40320;
      4'd9:    f = 29'd362880;
      4'd10:   f = 29'd3628800;
      4'd11:   f = 29'd39916800;
      4'd12:   f = 29'd479001600;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

>>> design/pu_divider.sv
// Restoring divider producing one small quotient digit (QW bits, one bit
// per cycle) and the remainder. Depends on pu_pkg.
module pu_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pu_pkg::rank_t       dividend_i,
  input  pu_pkg::rank_t       divisor_i,
  output pu_pkg::pu_div_rsp_t rsp_o
);
  import pu_pkg::*;

  localparam int unsigned CW = (QW > 1) ? $clog2(QW) : 1;
  localparam int unsigned TW = RANK_W + QW;

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  rank_t           rem_q, rem_d;
  rank_t           dsr_q, dsr_d;
  quot_t           quot_q, quot_d;
  logic [TW-1:0]   trial;
  logic [TW-1:0]   rem_ext;

  // One quotient bit per cycle, most significant first
  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    quot_d  = quot_q;
    trial   = TW'(dsr_q) << cnt_q;
    rem_ext = TW'(rem_q);
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CW'(QW - 1);
      rem_d  = dividend_i;
      dsr_d  = divisor_i;
      quot_d = '0;
    end else if (run_q) begin
      if (rem_ext >= trial) begin
        rem_d          = RANK_W'(rem_ext - trial);
        quot_d[cnt_q]  = 1'b1;
      end
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

`ifndef SYNTHESIS
  // A result only follows a running division
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q))
    else $error("divider done without a running division");
`endif

endmodule

>>> design/pu_pool.sv
// Ordered list of unused values: select an entry by index and close the
// gap behind it. Depends on pu_pkg.
module pu_pool (
  input  logic                 clk_i,
  input  pu_pkg::pu_pool_cmd_t cmd_i,
  output pu_pkg::elem_t        value_o
);
  import pu_pkg::*;

  elem_t pool_q [MAX_N];
  elem_t pool_d [MAX_N];

  // Selected value
  assign value_o = pool_q[cmd_i.idx];

  // Load 1..MAX_N, or remove the selected entry by shifting down
  always_comb begin
    for (int i = 0; i < MAX_N; i++) begin
      pool_d[i] = pool_q[i];
      if (cmd_i.init) begin
        pool_d[i] = ELEM_W'(i + 1);
      end else if (cmd_i.take && (IDX_W'(i) >= cmd_i.idx) && (i + 1 < MAX_N)) begin
        pool_d[i] = pool_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_N; i++) begin
      pool_q[i] <= pool_d[i];
    end
  end

endmodule

>>> design/permutation_unrank_top.sv
// Permutation unrank top level: sequencer around one divider, reused for
// every element, and the value pool. Depends on pu_pkg, pu_divider, pu_pool.
//
// Usage: drive req_i (length n, one-based rank k) and raise start; the
// request is taken at a clock edge where start is high and busy is low.
// The block then emits the k-th lexicographic permutation of 1..n, one
// element per result on result_o, each present for one cycle with
// valid_o high; the final element carries last. A request with n zero or
// above MAX_N, k zero, or k above n! yields one result with error and last
// set and element zero, in the cycle after acceptance.
// Each element passes through a division start state, the QW restoring
// steps of the divider, and a wait state that sees the divider done and
// does the select-and-remove step. Busy stays high until the last element
// is issued; the next request may be taken while that last result is on
// the outputs.
// The receiver cannot stall: every result is taken in its cycle.
// Reset clears the sequencer and the result strobe; nothing is pending.
module permutation_unrank_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  pu_pkg::pu_req_t     req_i,
  output logic                busy,
  output logic                valid_o,
  output pu_pkg::pu_result_t  result_o
);
  import pu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT
  } state_e;

  state_e       state_q, state_d;
  len_t         rem_cnt_q, rem_cnt_d;
  rank_t        k_q, k_d;
  logic         valid_q, valid_d;
  pu_result_t   result_q, result_d;
  logic         req_bad;
  logic         div_start;
  rank_t        divisor;
  pu_div_rsp_t  div_rsp;
  pu_pool_cmd_t pool_cmd;
  elem_t        pool_value;
  quot_t        digit;

  // Request screening
  assign req_bad = (req_i.length == '0) || (req_i.length > LEN_W'(MAX_N)) ||
                   (req_i.rank == '0) || (req_i.rank > fact_f(req_i.length));

  // Digit clamped to the remaining pool size
  assign digit   = (QW'(div_rsp.quot) >= QW'(rem_cnt_q)) ? QW'(rem_cnt_q - 1'b1)
                                                          : div_rsp.quot;
  assign divisor = fact_f(rem_cnt_q - 1'b1);

  pu_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (k_q),
    .divisor_i  (divisor),
    .rsp_o      (div_rsp)
  );

  pu_pool u_pool (
    .clk_i   (clk_i),
    .cmd_i   (pool_cmd),
    .value_o (pool_value)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    rem_cnt_d = rem_cnt_q;
    k_d       = k_q;
    valid_d   = 1'b0;
    result_d  = result_q;
    div_start = 1'b0;
    pool_cmd  = '{init: 1'b0, take: 1'b0, idx: digit};
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_bad) begin
            valid_d  = 1'b1;
            result_d = '{element: '0, last: 1'b1, error: 1'b1};
          end else begin
            rem_cnt_d     = req_i.length;
            k_d           = req_i.rank - 1'b1;
            pool_cmd.init = 1'b1;
            state_d       = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          pool_cmd.take = 1'b1;
          k_d           = div_rsp.rem;
          rem_cnt_d     = rem_cnt_q - 1'b1;
          valid_d       = 1'b1;
          result_d      = '{element: pool_value, last: (rem_cnt_q == LEN_W'(1)),
                            error: 1'b0};
          state_d       = (rem_cnt_q == LEN_W'(1)) ? ST_IDLE : ST_DIV;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_cnt_q <= rem_cnt_d;
    k_q       <= k_d;
    result_q  <= result_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  // An error result ends the request and carries no element
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.error |-> result_o.last && (result_o.element == '0))
    else $error("malformed error result");

  // A permutation element is never zero
  a_elem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.error |-> (result_o.element != '0))
    else $error("zero permutation element");

  // After the last element the block is free for a new request
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.last |-> !busy)
    else $error("busy after last result");

  // Divider completes only while waiting on it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_WAIT))
    else $error("divider result outside wait state");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for permutation_unrank_top: a factorial-base
// unrank predictor in a small scoreboard class checks every result in order.
// Depends on pu_pkg and the permutation_unrank_top RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pu_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANK_MAX    = (1 << RANK_W) - 1;

  // Scoreboard: expands each request into its expected elements
  class perm_scoreboard;
    pu_result_t  pending[$];
    int unsigned requests;
    int unsigned results;
    int unsigned flagged;
    int unsigned mismatches;

    static function longint unsigned fact_of(int unsigned m);
      longint unsigned f;
      f = 1;
      for (int unsigned i = 2; i <= m; i++) f *= i;
      return f;
    endfunction

    // Append one expected result at the tail
    function void add_expected(pu_result_t res);
      pending = {pending, res};
    endfunction

    // Factorial-base decode of rank-1, picking from the values still unused
    function void note_request(pu_req_t r);
      int unsigned     n;
      int unsigned     left;
      longint unsigned step;
      longint unsigned k;
      longint unsigned q;
      int unsigned     unused[$];
      pu_result_t      res;
      n = r.length;
      requests++;
      step = fact_of((n > 0) ? n - 1 : 0);
      if (n == 0 || n > MAX_N || r.rank == 0 || r.rank > step * n) begin
        res.element = '0;
        res.last    = 1'b1;
        res.error   = 1'b1;
        add_expected(res);
        return;
      end
      for (int unsigned v = 1; v <= n; v++) unused = {unused, v};
      k    = r.rank - 1;
      left = n;
      while (left > 0) begin
        q = k / step;
        if (q >= left) q = left - 1;
        res.element = elem_t'(unused[q]);
        unused.delete(q);
        left--;
        res.last  = (left == 0);
        res.error = 1'b0;
        add_expected(res);
        k = k % step;
        if (left > 0) step = step / left;
      end
    endfunction

    function void check_result(pu_result_t got);
      pu_result_t want;
      results++;
      if (got.error === 1'b1) flagged++;
      if (pending.size() == 0) begin
        $error("unexpected result: element %0d last %0b error %0b",
               got.element, got.last, got.error);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.element !== want.element) begin
        $error("element: expected %0d, got %0d", want.element, got.element);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %0b, got %0b", want.error, got.error);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  pu_req_t    req = '0;
  logic       busy;
  logic       valid;
  pu_result_t result;

  perm_scoreboard sb = new();
  int unsigned    idle_cycles = 0;

  permutation_unrank_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .req_i    (req),
    .busy     (busy),
    .valid_o  (valid),
    .result_o (result)
  );

  always #5 clk_i = ~clk_i;

  // Monitor: results first, then any request taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid) sb.check_result(result);
      if (start && !busy) sb.note_request(req);
    end
  end

  // Watchdog on cycles with no request and no result
  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without progress", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request at a falling edge, hold it until taken
  task automatic send_req(pu_req_t r, int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(15, 1)) @(negedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic send_pair(int unsigned n, longint unsigned k);
    pu_req_t r;
    r.length = len_t'(n);
    r.rank   = rank_t'(k);
    send_req(r, 0);
  endtask

  // Mostly legal ranks, with a share of each out-of-range kind
  function automatic pu_req_t random_req();
    pu_req_t         r;
    int unsigned     sel;
    int unsigned     n;
    longint unsigned total;
    sel = $urandom_range(99);
    n   = $urandom_range(MAX_N, 1);
    total = perm_scoreboard::fact_of(n);
    r.length = len_t'(n);
    if (sel < 85) begin
      r.rank = rank_t'($urandom_range(int'(total), 1));
    end else if (sel < 90) begin
      r.rank = '0;
    end else if (sel < 95) begin
      r.rank = rank_t'($urandom_range(RANK_MAX, int'(total) + 1));
    end else if (sel < 98) begin
      r.length = len_t'($urandom_range(15, MAX_N + 1));
      r.rank   = rank_t'($urandom_range(RANK_MAX));
    end else begin
      r.length = '0;
      r.rank   = rank_t'($urandom_range(RANK_MAX));
    end
    return r;
  endfunction

  int unsigned idle_pct[3] = '{0, 80, 17};

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: smallest and largest lengths, rank edges, bad requests
    send_pair(1, 1);
    send_pair(1, 0);
    send_pair(1, 2);
    send_pair(0, 1);
    send_pair(0, 0);
    send_pair(13, 1);
    send_pair(15, RANK_MAX);
    send_pair(15, 0);
    send_pair(2, 1);
    send_pair(2, 2);
    send_pair(2, 3);
    send_pair(3, 1);
    send_pair(3, 4);
    send_pair(3, 6);
    send_pair(5, 60);
    send_pair(11, perm_scoreboard::fact_of(11));
    send_pair(11, perm_scoreboard::fact_of(11) + 1);
    send_pair(12, 1);
    send_pair(12, perm_scoreboard::fact_of(12));
    send_pair(12, perm_scoreboard::fact_of(12) + 1);
    send_pair(12, RANK_MAX);
    send_pair(12, 268435456);

    // Random requests under each sender idling pattern
    foreach (idle_pct[p]) begin
      repeat (103) send_req(random_req(), idle_pct[p]);
    end
    start <= 1'b0;

    // Drain, then allow a few element times for stray results
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.mismatches++;
    end

    $display("Ran %0d requests, lengths 0..15 and ranks 0..2^29-1; %0d results checked",
             sb.requests, sb.results);
    $display("Rejected requests: %0d, mismatches: %0d", sb.flagged, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> permutation_unrank_top.f
design/pu_pkg.sv
design/pu_divider.sv
design/pu_pool.sv
design/permutation_unrank_top.sv
dv/tb_top.sv
